// ----- sv/sprite_xor_framebuffer_macros.svh -----
// Assertion macros shared by the framebuffer modules.
`ifndef SPRITE_XOR_FRAMEBUFFER_MACROS_SVH
`define SPRITE_XOR_FRAMEBUFFER_MACROS_SVH
`ifndef SYNTHESIS
`define SXFB_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sxfb assertion failed");
`define SXFB_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sxfb assertion failed");
`else
`define SXFB_ASSERT_IMP(name, clk, rstn, ante, cons)
`define SXFB_ASSERT_NXT(name, clk, rstn, ante, cons)
`endif
`endif

// ----- sv/sxfb_pkg.sv -----
// Types and constants for the sprite XOR framebuffer.
package sxfb_pkg;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_DRAW  = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_READ  = 2'd3
    } cmd_e;

    localparam logic [16:0] COUNT_MAX     = 17'h1FFFF;
    localparam logic [15:0] LEFTOVER_MAX  = 16'hFFFF;
    localparam logic [15:0] THRESH_RESET  = 16'd8;

    // item held in the input stage
    typedef struct packed {
        cmd_e        cmd;
        logic [5:0]  x_mod;
        logic [3:0]  row_index;
        logic [7:0]  sprite_byte;
        logic [15:0] cycles;
        logic        row_ok;
    } s1_item_t;

    typedef struct packed {
        logic we;
        logic clear;
    } mem_ctl_t;

    typedef struct packed {
        logic        accepted;
        logic        collision;
        logic [63:0] row_pixels;
        logic [15:0] leftover;
    } result_t;

endpackage

// ----- sv/sxfb_row_store.sv -----
// Framebuffer row memory with per-row valid bits and write forwarding.
`include "sprite_xor_framebuffer_macros.svh"
module sxfb_row_store #(
    parameter int ROWS = 32,
    parameter int AW   = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                re,
    input  logic [AW-1:0]       raddr,
    input  sxfb_pkg::mem_ctl_t  ctl,
    input  logic [AW-1:0]       waddr,
    input  logic [63:0]         wdata,
    output logic [63:0]         row_data
);

    logic [63:0]   mem [ROWS];
    logic [ROWS-1:0] row_valid_reg;
    logic [63:0]   rd_data_reg;
    logic          rd_valid_reg;
    logic          same_addr;

    assign same_addr = ctl.we && (waddr == raddr);

    always_ff @(posedge clk) begin
        if (ctl.we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rd_data_reg <= same_addr ? wdata : mem[raddr];
        end
    end

    // a row never written since the last clear reads as zero
    always_ff @(posedge clk) begin
        if (!rst_n) begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end else begin
            if (ctl.clear) begin
                row_valid_reg <= '0;
            end else if (ctl.we) begin
                row_valid_reg[waddr] <= 1'b1;
            end
            if (re) begin
                rd_valid_reg <= ctl.clear ? 1'b0 : (same_addr ? 1'b1 : row_valid_reg[raddr]);
            end
        end
    end

    assign row_data = rd_valid_reg ? rd_data_reg : 64'd0;

    `SXFB_ASSERT_NXT(a_clear_empties, clk, rst_n, ctl.clear, row_valid_reg == '0)
    `SXFB_ASSERT_NXT(a_write_marks, clk, rst_n, ctl.we, row_valid_reg[$past(waddr)])
    `SXFB_ASSERT_IMP(a_no_clear_and_write, clk, rst_n, ctl.clear, !ctl.we)

endmodule

// ----- sv/sxfb_core.sv -----
// Per-item execution: timing counter, collision flag, sprite XOR and result.
module sxfb_core #(
    parameter int SCREEN_COLS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_data,
    input  logic                step,
    input  sxfb_pkg::s1_item_t  item,
    input  logic [63:0]         row_data,
    output sxfb_pkg::mem_ctl_t  ctl,
    output logic [63:0]         wdata,
    output sxfb_pkg::result_t   result
);

    localparam logic [63:0] VIS_MASK = ~(64'hFFFF_FFFF_FFFF_FFFF >> SCREEN_COLS);

    logic [15:0] threshold_reg;
    logic [16:0] cycle_count_reg, cycle_count_next;
    logic        collision_reg, collision_next;

    logic        cnt_ok;
    logic [63:0] line;
    logic        hit;
    logic [16:0] extra;
    logic [16:0] base;
    logic [17:0] sum;

    assign cnt_ok = cycle_count_reg >= {1'b0, threshold_reg};
    assign line   = ({item.sprite_byte, 56'd0} >> item.x_mod) & VIS_MASK;
    assign hit    = (row_data & line) != 64'd0;
    assign wdata  = row_data ^ line;
    assign extra  = cnt_ok ? (cycle_count_reg - {1'b0, threshold_reg}) : 17'd0;
    assign base   = cnt_ok ? 17'd0 : cycle_count_reg;
    assign sum    = {1'b0, base} + {2'b00, item.cycles};

    always_comb begin
        cycle_count_next = cycle_count_reg;
        collision_next   = collision_reg;
        ctl.we           = 1'b0;
        ctl.clear        = 1'b0;
        result.accepted  = 1'b0;
        result.row_pixels = 64'd0;
        result.leftover  = 16'd0;
        case (item.cmd)
            sxfb_pkg::CMD_CLEAR: begin
                ctl.clear = step;
            end
            sxfb_pkg::CMD_DRAW: begin
                if (cnt_ok) begin
                    result.accepted = 1'b1;
                    ctl.we          = step && item.row_ok;
                    // row 0 restarts the flag before its own pixels count
                    collision_next  = ((item.row_index == 4'd0) ? 1'b0 : collision_reg)
                                      | (item.row_ok & hit);
                end
            end
            sxfb_pkg::CMD_TICK: begin
                if (extra == 17'd0) begin
                    cycle_count_next = (sum > {1'b0, sxfb_pkg::COUNT_MAX}) ?
                                       sxfb_pkg::COUNT_MAX : sum[16:0];
                end else begin
                    cycle_count_next = 17'd0;
                end
                result.leftover = extra[16] ? sxfb_pkg::LEFTOVER_MAX : extra[15:0];
            end
            sxfb_pkg::CMD_READ: begin
                if (item.row_ok) begin
                    result.row_pixels = row_data & VIS_MASK;
                end
            end
            default: begin
                ctl.we = 1'b0;
            end
        endcase
        result.collision = collision_next;
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            threshold_reg   <= sxfb_pkg::THRESH_RESET;
            cycle_count_reg <= 17'd0;
            collision_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                threshold_reg <= cfg_data;
            end
            if (step) begin
                cycle_count_reg <= cycle_count_next;
                collision_reg   <= collision_next;
            end
        end
    end

endmodule

// ----- sv/sprite_xor_framebuffer.sv -----
// Sprite XOR framebuffer top level: input stage, row store, core, result register.
// Throughput: one item per cycle while the result output does not stall.
// Stage 1 registers the item and the row read from the memory's single read port;
// stage 2 XORs, writes the row back and loads the result register.
// A back-to-back draw to the same row is forwarded around the memory. Reset (aresetn
// low, synchronous) empties the screen, zeroes counter and flag, sets threshold to 8.
`include "sprite_xor_framebuffer_macros.svh"
module sprite_xor_framebuffer #(
    parameter int SCREEN_COLS = 64,
    parameter int SCREEN_ROWS = 32,
    parameter int SPRITE_ROWS = 15
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [7:0]  s_x_origin,
    input  logic [7:0]  s_y_origin,
    input  logic [3:0]  s_row_index,
    input  logic [7:0]  s_sprite_byte,
    input  logic [15:0] s_cycles,
    input  logic [4:0]  s_row_select,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_accepted,
    output logic        m_collision,
    output logic [63:0] m_row_pixels,
    output logic [15:0] m_leftover_cycles
);

    localparam int AW = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;
    // reciprocal of the screen size, exact for 8-bit origins and sizes up to 64
    localparam logic [16:0] X_RECIP = 17'(65536 / SCREEN_COLS + 1);
    localparam logic [16:0] Y_RECIP = 17'(65536 / SCREEN_ROWS + 1);

    sxfb_pkg::s1_item_t s1_item_reg, s1_item_next;
    logic [AW-1:0]      s1_addr_reg, s1_addr_next;
    logic               s1_valid_reg;
    logic               m_valid_reg;
    sxfb_pkg::result_t  result_reg, result_next;

    sxfb_pkg::mem_ctl_t mem_ctl;
    logic [63:0]        mem_wdata;
    logic [63:0]        row_data;

    logic               out_load;
    logic               in_acc;
    sxfb_pkg::cmd_e     in_cmd;
    logic [23:0]        x_prod, y_prod;
    logic [7:0]         x_wrap, y_wrap;
    logic [6:0]         draw_row;
    logic [6:0]         addr7;
    logic               draw_ok, read_ok;

    assign out_load = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !s1_valid_reg || out_load;
    assign in_acc   = s_valid && s_ready;

    // address of the row this item touches
    assign in_cmd   = sxfb_pkg::cmd_e'(s_command);
    assign x_prod   = 24'(s_x_origin) * 24'(X_RECIP);
    assign y_prod   = 24'(s_y_origin) * 24'(Y_RECIP);
    assign x_wrap   = s_x_origin - 8'(16'(x_prod[23:16]) * 16'(SCREEN_COLS));
    assign y_wrap   = s_y_origin - 8'(16'(y_prod[23:16]) * 16'(SCREEN_ROWS));
    assign draw_row = 7'(y_wrap[5:0]) + 7'(s_row_index);
    assign draw_ok  = ({1'b0, s_row_index} < 5'(SPRITE_ROWS)) && (draw_row < 7'(SCREEN_ROWS));
    assign read_ok  = 7'(s_row_select) < 7'(SCREEN_ROWS);
    assign addr7    = (in_cmd == sxfb_pkg::CMD_DRAW) ? draw_row : 7'(s_row_select);

    always_comb begin
        s1_item_next.cmd         = in_cmd;
        s1_item_next.x_mod       = x_wrap[5:0];
        s1_item_next.row_index   = s_row_index;
        s1_item_next.sprite_byte = s_sprite_byte;
        s1_item_next.cycles      = s_cycles;
        s1_item_next.row_ok      = (in_cmd == sxfb_pkg::CMD_DRAW) ? draw_ok : read_ok;
        s1_addr_next             = addr7[AW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            s1_item_reg <= s1_item_next;
            s1_addr_reg <= s1_addr_next;
        end
        if (out_load) begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (in_acc) begin
                s1_valid_reg <= 1'b1;
            end else if (out_load) begin
                s1_valid_reg <= 1'b0;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    sxfb_row_store #(
        .ROWS (SCREEN_ROWS),
        .AW   (AW)
    ) u_row_store (
        .clk      (aclk),
        .rst_n    (aresetn),
        .re       (in_acc),
        .raddr    (s1_addr_next),
        .ctl      (mem_ctl),
        .waddr    (s1_addr_reg),
        .wdata    (mem_wdata),
        .row_data (row_data)
    );

    sxfb_core #(
        .SCREEN_COLS (SCREEN_COLS)
    ) u_core (
        .clk      (aclk),
        .rst_n    (aresetn),
        .cfg_we   (cfg_wr_en),
        .cfg_data (cfg_wr_data),
        .step     (out_load),
        .item     (s1_item_reg),
        .row_data (row_data),
        .ctl      (mem_ctl),
        .wdata    (mem_wdata),
        .result   (result_next)
    );

    assign m_valid           = m_valid_reg;
    assign m_accepted        = result_reg.accepted;
    assign m_collision       = result_reg.collision;
    assign m_row_pixels      = result_reg.row_pixels;
    assign m_leftover_cycles = result_reg.leftover;

    `SXFB_ASSERT_NXT(a_stage_holds, aclk, aresetn, s1_valid_reg && !out_load, s1_valid_reg)
    `SXFB_ASSERT_NXT(a_load_shows, aclk, aresetn, out_load, m_valid_reg)
    `SXFB_ASSERT_IMP(a_tick_only_leftover, aclk, aresetn,
                     m_valid_reg && (m_leftover_cycles != 16'd0),
                     !m_accepted && (m_row_pixels == 64'd0))
    `SXFB_ASSERT_IMP(a_draw_no_pixels, aclk, aresetn, m_valid_reg && m_accepted,
                     m_row_pixels == 64'd0)

endmodule

// ----- bench/framebuffer_checker.sv -----
`timescale 1ns / 100ps
// Framebuffer checker: mirrors screen, counter and collision flag, compares every result item.
module framebuffer_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [7:0]  s_x_origin,
    input  logic [7:0]  s_y_origin,
    input  logic [3:0]  s_row_index,
    input  logic [7:0]  s_sprite_byte,
    input  logic [15:0] s_cycles,
    input  logic [4:0]  s_row_select,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_accepted,
    input  logic        m_collision,
    input  logic [63:0] m_row_pixels,
    input  logic [15:0] m_leftover_cycles,
    output int          mismatches,
    output int          results_pending
);

    localparam int FB_COLS = 64;
    localparam int FB_ROWS = 32;
    localparam int SPRITE_DEPTH = 15;
    // shift by the full width gives zero, so a 64-column screen keeps every bit
    localparam logic [63:0] VISIBLE = ~(64'hFFFF_FFFF_FFFF_FFFF >> FB_COLS);

    typedef struct packed {
        logic        accepted;
        logic        collision;
        logic [63:0] row_pixels;
        logic [15:0] leftover;
    } screen_result_t;

    logic [63:0]    screen [FB_ROWS];
    logic [16:0]    cycle_total;
    logic           hit_flag;
    logic [15:0]    refresh_limit;
    screen_result_t results_due [$];

    function automatic screen_result_t run_command(
        input sxfb_pkg::cmd_e op,
        input logic [7:0]  x_org,
        input logic [7:0]  y_org,
        input logic [3:0]  sprite_row,
        input logic [7:0]  pattern,
        input logic [15:0] cyc,
        input logic [4:0]  sel
    );
        screen_result_t res;
        int             r;
        int             target;
        int             shift;
        logic [63:0]    line;
        logic [17:0]    extra;
        logic [17:0]    sum;
        res = '0;
        case (op)
            sxfb_pkg::CMD_CLEAR: begin
                for (r = 0; r < FB_ROWS; r++)
                    screen[r] = '0;
            end
            sxfb_pkg::CMD_DRAW: begin
                if (cycle_total >= {1'b0, refresh_limit}) begin
                    res.accepted = 1'b1;
                    shift = x_org % FB_COLS;
                    target = (y_org % FB_ROWS) + sprite_row;
                    if (sprite_row == 4'd0)
                        hit_flag = 1'b0;
                    if (sprite_row < SPRITE_DEPTH && target < FB_ROWS) begin
                        line = ({pattern, 56'd0} >> shift) & VISIBLE;
                        if ((screen[target] & line) != '0)
                            hit_flag = 1'b1;
                        screen[target] = screen[target] ^ line;
                    end
                end
            end
            sxfb_pkg::CMD_TICK: begin
                extra = '0;
                if (cycle_total >= {1'b0, refresh_limit}) begin
                    extra = cycle_total - refresh_limit;
                    cycle_total = '0;
                end
                if (extra == '0) begin
                    sum = cycle_total + cyc;
                    cycle_total = (sum > sxfb_pkg::COUNT_MAX) ? sxfb_pkg::COUNT_MAX : sum[16:0];
                end
                res.leftover = (extra > sxfb_pkg::LEFTOVER_MAX) ? sxfb_pkg::LEFTOVER_MAX
                                                                : extra[15:0];
            end
            default: begin
                if (sel < FB_ROWS)
                    res.row_pixels = screen[sel] & VISIBLE;
            end
        endcase
        res.collision = hit_flag;
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("checker: %s expected %h got %h at %0t", name, want, got, $time);
        end
    endfunction

    always @(posedge aclk) begin : watch
        screen_result_t want;
        if (!aresetn) begin
            for (int r = 0; r < FB_ROWS; r++)
                screen[r] = '0;
            cycle_total = '0;
            hit_flag = 1'b0;
            refresh_limit = sxfb_pkg::THRESH_RESET;
            results_due.delete();
        end else begin
            if (cfg_wr_en)
                refresh_limit = cfg_wr_data;
            // compare before queueing: a result never belongs to the item taken this edge
            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("checker: result item with none expected at %0t", $time);
                end else begin
                    want = results_due.pop_front();
                    check_field("accepted", want.accepted, m_accepted);
                    check_field("collision", want.collision, m_collision);
                    check_field("row_pixels", want.row_pixels, m_row_pixels);
                    check_field("leftover_cycles", want.leftover, m_leftover_cycles);
                end
            end
            if (s_valid && s_ready)
                results_due.push_back(run_command(sxfb_pkg::cmd_e'(s_command), s_x_origin,
                    s_y_origin, s_row_index, s_sprite_byte, s_cycles, s_row_select));
        end
        results_pending = results_due.size();
    end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// Testbench top: clock, reset, directed and random stimulus, threshold phases, verdict.
module tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 80;

    typedef struct {
        sxfb_pkg::cmd_e command;
        logic [7:0]  x_origin;
        logic [7:0]  y_origin;
        logic [3:0]  row_index;
        logic [7:0]  sprite_byte;
        logic [15:0] cycles;
        logic [4:0]  row_select;
    } screen_op_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_command;
    logic [7:0]  s_x_origin;
    logic [7:0]  s_y_origin;
    logic [3:0]  s_row_index;
    logic [7:0]  s_sprite_byte;
    logic [15:0] s_cycles;
    logic [4:0]  s_row_select;
    logic        m_valid;
    logic        m_ready;
    logic        m_accepted;
    logic        m_collision;
    logic [63:0] m_row_pixels;
    logic [15:0] m_leftover_cycles;
    int          mismatches;
    int          results_pending;

    int          send_idle_pct;
    int          recv_stall_pct;
    int          items_sent;
    int          cycle_no;
    logic [15:0] threshold_now;

    sprite_xor_framebuffer dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command),
        .s_x_origin(s_x_origin), .s_y_origin(s_y_origin), .s_row_index(s_row_index),
        .s_sprite_byte(s_sprite_byte), .s_cycles(s_cycles), .s_row_select(s_row_select),
        .m_valid(m_valid), .m_ready(m_ready), .m_accepted(m_accepted),
        .m_collision(m_collision), .m_row_pixels(m_row_pixels),
        .m_leftover_cycles(m_leftover_cycles)
    );

    framebuffer_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command),
        .s_x_origin(s_x_origin), .s_y_origin(s_y_origin), .s_row_index(s_row_index),
        .s_sprite_byte(s_sprite_byte), .s_cycles(s_cycles), .s_row_select(s_row_select),
        .m_valid(m_valid), .m_ready(m_ready), .m_accepted(m_accepted),
        .m_collision(m_collision), .m_row_pixels(m_row_pixels),
        .m_leftover_cycles(m_leftover_cycles),
        .mismatches(mismatches), .results_pending(results_pending)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_no++;
        if (cycle_no >= CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic screen_op_t random_op(input sxfb_pkg::cmd_e kind);
        screen_op_t op;
        op.command     = kind;
        op.x_origin    = 8'($urandom);
        op.y_origin    = 8'($urandom);
        op.row_index   = 4'($urandom);
        op.sprite_byte = 8'($urandom);
        op.cycles      = 16'($urandom);
        op.row_select  = 5'($urandom);
        return op;
    endfunction

    // entered at a falling edge; valid is left high after the handshake for the next item
    task automatic send_op(input screen_op_t op);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_command     <= op.command;
        s_x_origin    <= op.x_origin;
        s_y_origin    <= op.y_origin;
        s_row_index   <= op.row_index;
        s_sprite_byte <= op.sprite_byte;
        s_cycles      <= op.cycles;
        s_row_select  <= op.row_select;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        @(negedge aclk);
        items_sent++;
    endtask

    task automatic draw_row(input logic [7:0] x, input logic [7:0] y, input logic [3:0] ri,
                            input logic [7:0] pattern);
        screen_op_t op;
        op = random_op(sxfb_pkg::CMD_DRAW);
        op.x_origin = x;
        op.y_origin = y;
        op.row_index = ri;
        op.sprite_byte = pattern;
        send_op(op);
    endtask

    task automatic tick(input logic [15:0] cyc);
        screen_op_t op;
        op = random_op(sxfb_pkg::CMD_TICK);
        op.cycles = cyc;
        send_op(op);
    endtask

    task automatic read_row(input logic [4:0] sel);
        screen_op_t op;
        op = random_op(sxfb_pkg::CMD_READ);
        op.row_select = sel;
        send_op(op);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do
            @(negedge aclk);
        while (results_pending != 0);
    endtask

    task automatic write_threshold(input logic [15:0] value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        threshold_now = value;
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input logic [15:0] thr);
        int          target;
        int          pick;
        int          rows;
        logic [7:0]  x;
        logic [7:0]  y;
        write_threshold(thr);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        target = items_sent + PHASE_ITEMS;
        while (items_sent < target) begin
            if ($urandom_range(99) < 3)
                drain();
            pick = $urandom_range(99);
            if (pick < 55) begin
                // arm the counter, then up to 15 rows of a sprite at one origin
                if ($urandom_range(9) < 8)
                    tick(threshold_now);
                else
                    tick(16'($urandom));
                rows = $urandom_range(1, 15);
                x = 8'($urandom);
                y = 8'($urandom);
                for (int k = 0; k < rows; k++)
                    draw_row(x, y, ($urandom_range(9) == 0) ? 4'($urandom) : 4'(k),
                             8'($urandom));
            end else if (pick < 75) begin
                read_row(5'($urandom));
            end else if (pick < 87) begin
                tick($urandom_range(1) ? 16'($urandom) : 16'($urandom_range(63)));
            end else if (pick < 92) begin
                send_op(random_op(sxfb_pkg::CMD_CLEAR));
            end else begin
                send_op(random_op(sxfb_pkg::cmd_e'($urandom_range(3))));
            end
        end
        drain();
    endtask

    initial begin
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        s_valid        = 1'b0;
        s_command      = sxfb_pkg::CMD_CLEAR;
        s_x_origin     = '0;
        s_y_origin     = '0;
        s_row_index    = '0;
        s_sprite_byte  = '0;
        s_cycles       = '0;
        s_row_select   = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        items_sent     = 0;
        threshold_now  = sxfb_pkg::THRESH_RESET;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        read_row(5'd0);
        draw_row(8'd0, 8'd0, 4'd0, 8'hFF);      // refused, counter still zero
        tick(16'd8);
        draw_row(8'd0, 8'd0, 4'd0, 8'hFF);
        draw_row(8'd0, 8'd0, 4'd0, 8'h81);      // flag restarts, then hits
        draw_row(8'd60, 8'd33, 4'd1, 8'hFF);    // clipped at right edge, y wraps
        draw_row(8'd255, 8'd255, 4'd0, 8'hFF);  // both origins wrap to the far corner
        draw_row(8'd0, 8'd31, 4'd1, 8'hFF);     // falls below the screen
        draw_row(8'd8, 8'd4, 4'd15, 8'hAA);     // row past the sprite
        draw_row(8'd128, 8'd17, 4'd14, 8'h55);
        draw_row(8'd3, 8'd0, 4'd0, 8'h00);
        read_row(5'd0);
        read_row(5'd2);
        read_row(5'd31);
        read_row(5'd16);
        tick(16'd0);                            // exactly at threshold
        draw_row(8'd0, 8'd0, 4'd0, 8'hFF);
        tick(16'hFFFF);
        tick(16'd100);
        send_op(random_op(sxfb_pkg::CMD_CLEAR));
        read_row(5'd0);

        // push the counter past 16 bits, then drop the threshold so the leftover saturates
        write_threshold(16'hFFFF);
        tick(16'hFFFE);
        tick(16'hFFFF);
        write_threshold(16'd1);
        tick(16'd0);
        tick(16'd1);
        draw_row(8'd10, 8'd5, 4'd0, 8'hC3);

        run_phase(0, 0, 16'd1);
        run_phase(74, 0, 16'hFFFF);
        run_phase(0, 74, 16'($urandom_range(2, 300)));
        run_phase(22, 22, 16'($urandom_range(1, 65535)));
        run_phase(0, 0, sxfb_pkg::THRESH_RESET);

        repeat (8) @(posedge aclk);
        if (mismatches == 0 && results_pending == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
